### rtl/core/hkct_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the hotkey command translator.
// No dependencies; every other file of the block imports this package.
package hkct_pkg;

    // Request codes as they arrive on the input channel
    localparam logic [2:0] REQ_KEY_EVENT = 3'd0;
    localparam logic [2:0] REQ_LOOKUP    = 3'd1;
    localparam logic [2:0] REQ_END_FRAME = 3'd2;
    localparam logic [2:0] REQ_FORCE_ON  = 3'd3;
    localparam logic [2:0] REQ_ADD       = 3'd4;

    // Modifier rule codes
    localparam logic [1:0] RULE_EITHER = 2'd0;
    localparam logic [1:0] RULE_DOWN   = 2'd1;
    localparam logic [1:0] RULE_UP     = 2'd2;
    localparam logic [1:0] RULE_NEVER  = 2'd3;

    localparam int unsigned FLAG_W = 64;

    typedef enum logic [2:0] {
        OP_KEY,
        OP_LOOKUP,
        OP_END_FRAME,
        OP_FORCE_ON,
        OP_ADD,
        OP_NOP
    } op_t;

    // Classified request as it travels from front to back
    typedef struct packed {
        op_t        op;
        logic [7:0] scan_code;
        logic       key_pressed;
        logic       ctrl_down;
        logic       shift_down;
        logic       alt_down;
        logic       force_clear;
        logic [5:0] command_num;
        logic [1:0] ctrl_rule;
        logic [1:0] shift_rule;
        logic [1:0] alt_rule;
    } req_t;

    // One binding table entry, 20 bits
    typedef struct packed {
        logic [7:0] scan_code;
        logic [1:0] ctrl_rule;
        logic [1:0] shift_rule;
        logic [1:0] alt_rule;
        logic [5:0] command_num;
    } bind_t;

    function automatic logic rule_ok(input logic [1:0] rule, input logic held);
        logic ok;
        unique case (rule)
            RULE_EITHER: ok = 1'b1;
            RULE_DOWN:   ok = held;
            RULE_UP:     ok = !held;
            RULE_NEVER:  ok = 1'b0;
            default:     ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic mods_ok(input bind_t b, input logic c, input logic s,
                                     input logic a);
        return rule_ok(b.ctrl_rule, c) && rule_ok(b.shift_rule, s)
            && rule_ok(b.alt_rule, a);
    endfunction

endpackage

### rtl/core/hotkey_command_translator.sv
`timescale 1ns / 1ps
// Hotkey command translator: maps key events to per-command on flags.
// Top level; instantiates hkct_front, hkct_queue and hkct_back (hkct_pkg).
//
// Usage: requests enter on the s_ channel (valid/ready), one result per
// request leaves on the m_ channel (valid/ready). Request types are key
// event, lookup, end of frame, force on and add binding; others give an
// all-zero result with the current on mask.
// A request passes the front register and the two-entry queue, then the
// back end runs it. End of frame, force on and add finish in the back
// end's idle state, which loads the result register directly.
// A key event steps through every stored binding, and a lookup through the
// bindings up to and including the first full match, after a start step
// in the idle state; the walk is set by the single read port of the
// binding memory. The back end takes a new request only once it is idle.
// Reset clears the binding count and all command flags; the table contents
// need no clearing. When the receiver stalls, the result register holds,
// the back end waits, and the front keeps taking requests until the queue
// and the front register are full.
module hotkey_command_translator #(
    parameter int unsigned TABLE_ENTRIES = 256,
    parameter int unsigned NUM_COMMANDS  = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [7:0]  s_scan_code,
    input  logic        s_key_pressed,
    input  logic        s_ctrl_down,
    input  logic        s_shift_down,
    input  logic        s_alt_down,
    input  logic        s_force_clear,
    input  logic [5:0]  s_command_num,
    input  logic [1:0]  s_ctrl_rule,
    input  logic [1:0]  s_shift_rule,
    input  logic [1:0]  s_alt_rule,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [5:0]  m_matched_command,
    output logic        m_accepted,
    output logic [63:0] m_on_mask
);
    import hkct_pkg::*;

    logic push_valid, push_ready;
    req_t push_req;
    logic pop_valid, pop_ready;
    req_t pop_req;

    hkct_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_scan_code   (s_scan_code),
        .s_key_pressed (s_key_pressed),
        .s_ctrl_down   (s_ctrl_down),
        .s_shift_down  (s_shift_down),
        .s_alt_down    (s_alt_down),
        .s_force_clear (s_force_clear),
        .s_command_num (s_command_num),
        .s_ctrl_rule   (s_ctrl_rule),
        .s_shift_rule  (s_shift_rule),
        .s_alt_rule    (s_alt_rule),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_req      (push_req)
    );

    hkct_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_req   (push_req),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_req   (pop_req)
    );

    hkct_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NUM_COMMANDS  (NUM_COMMANDS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (pop_valid),
        .q_ready           (pop_ready),
        .q_req             (pop_req),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_found           (m_found),
        .m_matched_command (m_matched_command),
        .m_accepted        (m_accepted),
        .m_on_mask         (m_on_mask)
    );

endmodule

### rtl/core/hkct_front.sv
`timescale 1ns / 1ps
// Front end: accepts input requests, decodes the request type and
// registers the classified request for the queue. Depends on hkct_pkg.
module hkct_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_req_type,
    input  logic [7:0]         s_scan_code,
    input  logic               s_key_pressed,
    input  logic               s_ctrl_down,
    input  logic               s_shift_down,
    input  logic               s_alt_down,
    input  logic               s_force_clear,
    input  logic [5:0]         s_command_num,
    input  logic [1:0]         s_ctrl_rule,
    input  logic [1:0]         s_shift_rule,
    input  logic [1:0]         s_alt_rule,
    output logic               push_valid,
    input  logic               push_ready,
    output hkct_pkg::req_t     push_req
);
    import hkct_pkg::*;

    logic hold_valid_reg, hold_valid_next;
    req_t hold_req_reg, hold_req_next;
    op_t  op_dec;

    always_comb begin
        unique case (s_req_type)
            REQ_KEY_EVENT: op_dec = OP_KEY;
            REQ_LOOKUP:    op_dec = OP_LOOKUP;
            REQ_END_FRAME: op_dec = OP_END_FRAME;
            REQ_FORCE_ON:  op_dec = OP_FORCE_ON;
            REQ_ADD:       op_dec = OP_ADD;
            default:       op_dec = OP_NOP;
        endcase
    end

    assign s_ready    = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_req   = hold_req_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg && !push_ready;
        hold_req_next   = hold_req_reg;
        if (s_valid && s_ready) begin
            hold_valid_next          = 1'b1;
            hold_req_next.op          = op_dec;
            hold_req_next.scan_code   = s_scan_code;
            hold_req_next.key_pressed = s_key_pressed;
            hold_req_next.ctrl_down   = s_ctrl_down;
            hold_req_next.shift_down  = s_shift_down;
            hold_req_next.alt_down    = s_alt_down;
            hold_req_next.force_clear = s_force_clear;
            hold_req_next.command_num = s_command_num;
            hold_req_next.ctrl_rule   = s_ctrl_rule;
            hold_req_next.shift_rule  = s_shift_rule;
            hold_req_next.alt_rule    = s_alt_rule;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_req_reg <= hold_req_next;
    end

endmodule

### rtl/core/hkct_queue.sv
`timescale 1ns / 1ps
// Two-entry request queue between front and back end.
// Depends on hkct_pkg for the request type.
module hkct_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  hkct_pkg::req_t wr_req,
    output logic           rd_valid,
    input  logic           rd_ready,
    output hkct_pkg::req_t rd_req
);
    import hkct_pkg::*;

    req_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_wr, do_rd;

    assign wr_ready = (fill_reg != 2'd2);
    assign rd_valid = (fill_reg != 2'd0);
    assign rd_req   = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        fill_next   = fill_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_req;
        end
    end

endmodule

### rtl/core/hkct_back.sv
`timescale 1ns / 1ps
// Back end: owns the binding memory and the command flags, carries out
// each request and holds the result register. Depends on hkct_pkg.
module hkct_back #(
    parameter int unsigned TABLE_ENTRIES = 256,
    parameter int unsigned NUM_COMMANDS  = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  hkct_pkg::req_t q_req,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_found,
    output logic [5:0]     m_matched_command,
    output logic           m_accepted,
    output logic [63:0]    m_on_mask
);
    import hkct_pkg::*;

    localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] DEPTH = CW'(TABLE_ENTRIES);
    localparam logic [FLAG_W-1:0] CMD_MASK = (NUM_COMMANDS >= 64) ? '1 :
        ((FLAG_W'(1) << NUM_COMMANDS) - FLAG_W'(1));

    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

    bind_t mem [TABLE_ENTRIES];
    bind_t rdata_reg;

    state_t            state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     count_reg, count_next;
    req_t              req_reg, req_next;
    logic              found_reg, found_next;
    logic [FLAG_W-1:0] on_reg, on_next;
    logic [FLAG_W-1:0] pr_reg, pr_next;
    logic [FLAG_W-1:0] rs_reg, rs_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_found_reg, m_found_next;
    logic [5:0]        m_cmd_reg, m_cmd_next;
    logic              m_acc_reg, m_acc_next;
    logic [FLAG_W-1:0] m_on_reg, m_on_next;

    logic              out_free;
    logic              wr_en;
    bind_t             wr_data;
    logic [AW-1:0]     rd_addr;
    logic [CW-1:0]     idx_inc;
    logic [FLAG_W-1:0] ent_bit;
    logic [FLAG_W-1:0] q_bit;
    logic              ent_match;
    logic              ent_mods;
    logic              last_ent;

    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = (state_reg == S_IDLE) && out_free;
    assign idx_inc  = CW'(idx_reg) + CW'(1);
    assign last_ent = (idx_inc >= count_reg);
    assign ent_bit  = (FLAG_W'(1) << rdata_reg.command_num) & CMD_MASK;
    assign q_bit    = (FLAG_W'(1) << q_req.command_num) & CMD_MASK;
    assign ent_match = (rdata_reg.scan_code == req_reg.scan_code);
    assign ent_mods  = mods_ok(rdata_reg, req_reg.ctrl_down, req_reg.shift_down,
                               req_reg.alt_down);
    assign rd_addr  = (state_reg == S_IDLE) ? '0 : idx_inc[AW-1:0];

    assign wr_data.scan_code   = q_req.scan_code;
    assign wr_data.ctrl_rule   = q_req.ctrl_rule;
    assign wr_data.shift_rule  = q_req.shift_rule;
    assign wr_data.alt_rule    = q_req.alt_rule;
    assign wr_data.command_num = q_req.command_num;

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        req_next     = req_reg;
        found_next   = found_reg;
        on_next      = on_reg;
        pr_next      = pr_reg;
        rs_next      = rs_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_found_next = m_found_reg;
        m_cmd_next   = m_cmd_reg;
        m_acc_next   = m_acc_reg;
        m_on_next    = m_on_reg;
        wr_en        = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid && out_free) begin
                    req_next     = q_req;
                    found_next   = 1'b0;
                    idx_next     = '0;
                    m_found_next = 1'b0;
                    m_cmd_next   = '0;
                    m_acc_next   = 1'b0;
                    unique case (q_req.op)
                        OP_KEY, OP_LOOKUP: begin
                            if (count_reg != '0) begin
                                state_next = S_WALK;
                            end else begin
                                m_valid_next = 1'b1;
                            end
                        end
                        OP_END_FRAME: begin
                            if (q_req.force_clear) begin
                                on_next = '0;
                                pr_next = '0;
                            end else begin
                                on_next = on_reg & ~rs_reg;
                            end
                            rs_next      = '0;
                            m_valid_next = 1'b1;
                        end
                        OP_FORCE_ON: begin
                            if ((q_bit != '0) && ((on_reg & q_bit) == '0)) begin
                                on_next = on_reg | q_bit;
                                rs_next = rs_reg | q_bit;
                            end
                            m_valid_next = 1'b1;
                        end
                        OP_ADD: begin
                            if (count_reg < DEPTH) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CW'(1);
                                m_acc_next = 1'b1;
                            end
                            m_valid_next = 1'b1;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                    m_on_next = on_next;
                end
            end
            S_WALK: begin
                idx_next = idx_inc[AW-1:0];
                if (req_reg.op == OP_LOOKUP) begin
                    if (ent_match && ent_mods) begin
                        m_found_next = 1'b1;
                        m_cmd_next   = rdata_reg.command_num;
                        m_valid_next = 1'b1;
                        m_on_next    = on_reg;
                        state_next   = S_IDLE;
                    end else if (last_ent) begin
                        m_valid_next = 1'b1;
                        m_on_next    = on_reg;
                        state_next   = S_IDLE;
                    end
                end else begin
                    found_next = found_reg | ent_match;
                    if (!req_reg.key_pressed && ent_match) begin
                        rs_next = rs_reg | ent_bit;
                        pr_next = pr_reg & ~ent_bit;
                    end else begin
                        if (ent_match) begin
                            pr_next = pr_reg | ent_bit;
                        end
                        if (ent_mods) begin
                            // on follows the pressed flag as just updated
                            if ((pr_next & ent_bit) != '0) begin
                                on_next = on_reg | ent_bit;
                                rs_next = rs_reg & ~ent_bit;
                            end
                        end else begin
                            rs_next = rs_reg | ent_bit;
                        end
                    end
                    if (last_ent) begin
                        m_found_next = found_next;
                        m_valid_next = 1'b1;
                        m_on_next    = on_next;
                        state_next   = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Binding memory: one write port for adds, one registered read port for walks
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[count_reg[AW-1:0]] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            on_reg      <= '0;
            pr_reg      <= '0;
            rs_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            on_reg      <= on_next;
            pr_reg      <= pr_next;
            rs_reg      <= rs_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg     <= idx_next;
        req_reg     <= req_next;
        found_reg   <= found_next;
        m_found_reg <= m_found_next;
        m_cmd_reg   <= m_cmd_next;
        m_acc_reg   <= m_acc_next;
        m_on_reg    <= m_on_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_found           = m_found_reg;
    assign m_matched_command = m_cmd_reg;
    assign m_accepted        = m_acc_reg;
    assign m_on_mask         = m_on_reg;

endmodule

### sim/hotkey_command_translator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for hotkey_command_translator: queued requests with random idling,
// results scored against a behavioral copy of the binding table and command flags.
// Depends on hkct_pkg and the block's RTL only.
module hotkey_command_translator_tb;
    import hkct_pkg::*;

    localparam int TABLE_N  = 256;
    localparam int CMD_N    = 64;
    localparam int BUSY_CAP = 48;     // table size kept during the random phase
    localparam int RAND_N   = 1550;
    localparam int WATCHDOG = 5000;
    localparam int TAIL     = 20;

    typedef struct packed {
        logic       drain_first;
        logic [2:0] req_type;
        logic [7:0] scan_code;
        logic       key_pressed;
        logic       ctrl_down;
        logic       shift_down;
        logic       alt_down;
        logic       force_clear;
        logic [5:0] command_num;
        logic [1:0] ctrl_rule;
        logic [1:0] shift_rule;
        logic [1:0] alt_rule;
    } hotkey_req_t;

    typedef struct packed {
        logic        found;
        logic [5:0]  matched_command;
        logic        accepted;
        logic [63:0] on_mask;
    } outcome_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [2:0]  s_req_type    = '0;
    logic [7:0]  s_scan_code   = '0;
    logic        s_key_pressed = 1'b0;
    logic        s_ctrl_down   = 1'b0;
    logic        s_shift_down  = 1'b0;
    logic        s_alt_down    = 1'b0;
    logic        s_force_clear = 1'b0;
    logic [5:0]  s_command_num = '0;
    logic [1:0]  s_ctrl_rule   = '0;
    logic [1:0]  s_shift_rule  = '0;
    logic [1:0]  s_alt_rule    = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic        m_found;
    logic [5:0]  m_matched_command;
    logic        m_accepted;
    logic [63:0] m_on_mask;

    hotkey_command_translator #(
        .TABLE_ENTRIES (TABLE_N),
        .NUM_COMMANDS  (CMD_N)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_req_type        (s_req_type),
        .s_scan_code       (s_scan_code),
        .s_key_pressed     (s_key_pressed),
        .s_ctrl_down       (s_ctrl_down),
        .s_shift_down      (s_shift_down),
        .s_alt_down        (s_alt_down),
        .s_force_clear     (s_force_clear),
        .s_command_num     (s_command_num),
        .s_ctrl_rule       (s_ctrl_rule),
        .s_shift_rule      (s_shift_rule),
        .s_alt_rule        (s_alt_rule),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_found           (m_found),
        .m_matched_command (m_matched_command),
        .m_accepted        (m_accepted),
        .m_on_mask         (m_on_mask)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Binding table and command flags as the block should hold them
    bind_t       pred_bindings [TABLE_N];
    int          pred_count   = 0;
    logic [63:0] on_bits      = '0;
    logic [63:0] pressed_bits = '0;
    logic [63:0] reset_bits   = '0;
    int          adds_refused = 0;

    function automatic logic rule_allows(input logic [1:0] rule, input logic held);
        case (rule)
            RULE_EITHER: return 1'b1;
            RULE_DOWN:   return held;
            RULE_UP:     return !held;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic logic mods_allow(input bind_t b, input hotkey_req_t r);
        return rule_allows(b.ctrl_rule, r.ctrl_down) && rule_allows(b.shift_rule, r.shift_down)
            && rule_allows(b.alt_rule, r.alt_down);
    endfunction

    function automatic outcome_t translate_request(input hotkey_req_t r);
        outcome_t    o;
        bind_t       b;
        logic [63:0] cmd_ok;
        logic [63:0] bit_c;
        logic        hit;
        logic        done;
        int          i;
        o      = '0;
        cmd_ok = (CMD_N >= 64) ? '1 : ((64'd1 << CMD_N) - 64'd1);
        case (r.req_type)
            REQ_KEY_EVENT: begin
                for (i = 0; i < pred_count; i++) begin
                    b     = pred_bindings[i];
                    bit_c = (64'd1 << b.command_num) & cmd_ok;
                    hit   = (b.scan_code == r.scan_code);
                    if (hit) o.found = 1'b1;
                    if (hit && !r.key_pressed) begin
                        reset_bits   |= bit_c;
                        pressed_bits &= ~bit_c;
                    end else begin
                        if (hit) pressed_bits |= bit_c;
                        if (mods_allow(b, r)) begin
                            if ((pressed_bits & bit_c) != 0) begin
                                on_bits    |= bit_c;
                                reset_bits &= ~bit_c;
                            end
                        end else begin
                            reset_bits |= bit_c;
                        end
                    end
                end
            end
            REQ_LOOKUP: begin
                done = 1'b0;
                for (i = 0; i < pred_count; i++) begin
                    b = pred_bindings[i];
                    if (!done && b.scan_code == r.scan_code && mods_allow(b, r)) begin
                        o.found           = 1'b1;
                        o.matched_command = b.command_num;
                        done              = 1'b1;
                    end
                end
            end
            REQ_END_FRAME: begin
                if (r.force_clear) begin
                    on_bits      = '0;
                    pressed_bits = '0;
                end else begin
                    on_bits &= ~reset_bits;
                end
                reset_bits = '0;
            end
            REQ_FORCE_ON: begin
                bit_c = (64'd1 << r.command_num) & cmd_ok;
                if (bit_c != 0 && (on_bits & bit_c) == 0) begin
                    on_bits    |= bit_c;
                    reset_bits |= bit_c;
                end
            end
            REQ_ADD: begin
                if (pred_count < TABLE_N) begin
                    b.scan_code   = r.scan_code;
                    b.ctrl_rule   = r.ctrl_rule;
                    b.shift_rule  = r.shift_rule;
                    b.alt_rule    = r.alt_rule;
                    b.command_num = r.command_num;
                    pred_bindings[pred_count] = b;
                    pred_count++;
                    o.accepted = 1'b1;
                end else begin
                    adds_refused++;
                end
            end
            default: ;
        endcase
        o.on_mask = on_bits;
        return o;
    endfunction

    // Request generation
    hotkey_req_t request_q [$];
    outcome_t    outcome_q [$];
    logic        hold_for_drain = 1'b0;
    int          gen_count      = 0;
    logic [7:0]  bound_scans [$];

    function automatic hotkey_req_t random_req();
        hotkey_req_t r;
        r.drain_first = 1'b0;
        r.req_type    = 3'($urandom_range(7));
        r.scan_code   = 8'($urandom_range(255));
        r.key_pressed = 1'($urandom_range(1));
        r.ctrl_down   = 1'($urandom_range(1));
        r.shift_down  = 1'($urandom_range(1));
        r.alt_down    = 1'($urandom_range(1));
        r.force_clear = 1'($urandom_range(1));
        r.command_num = 6'($urandom_range(63));
        r.ctrl_rule   = 2'($urandom_range(3));
        r.shift_rule  = 2'($urandom_range(3));
        r.alt_rule    = 2'($urandom_range(3));
        return r;
    endfunction

    function automatic logic [7:0] pick_scan();
        if (bound_scans.size() != 0 && $urandom_range(4) != 0)
            return bound_scans[$urandom_range(bound_scans.size() - 1)];
        return 8'($urandom_range(255));
    endfunction

    // Mostly a small pool so several bindings share a command
    function automatic logic [5:0] pick_command();
        if ($urandom_range(3) == 0) return 6'($urandom_range(63));
        return 6'($urandom_range(7));
    endfunction

    task automatic enqueue(input hotkey_req_t r);
        r.drain_first  = hold_for_drain;
        hold_for_drain = 1'b0;
        request_q      = {request_q, r};
    endtask

    task automatic push_key(input logic [7:0] scan, input logic pressed,
                            input logic c, input logic s, input logic a);
        hotkey_req_t r;
        r = random_req();
        r.req_type    = REQ_KEY_EVENT;
        r.scan_code   = scan;
        r.key_pressed = pressed;
        r.ctrl_down   = c;
        r.shift_down  = s;
        r.alt_down    = a;
        enqueue(r);
    endtask

    task automatic push_lookup(input logic [7:0] scan, input logic c, input logic s,
                               input logic a);
        hotkey_req_t r;
        r = random_req();
        r.req_type   = REQ_LOOKUP;
        r.scan_code  = scan;
        r.ctrl_down  = c;
        r.shift_down = s;
        r.alt_down   = a;
        enqueue(r);
    endtask

    task automatic push_frame(input logic clear_all);
        hotkey_req_t r;
        r = random_req();
        r.req_type    = REQ_END_FRAME;
        r.force_clear = clear_all;
        enqueue(r);
    endtask

    task automatic push_force(input logic [5:0] cmd);
        hotkey_req_t r;
        r = random_req();
        r.req_type    = REQ_FORCE_ON;
        r.command_num = cmd;
        enqueue(r);
    endtask

    task automatic push_add(input logic [7:0] scan, input logic [5:0] cmd,
                            input logic [1:0] cr, input logic [1:0] sr, input logic [1:0] ar);
        hotkey_req_t r;
        r = random_req();
        r.req_type    = REQ_ADD;
        r.scan_code   = scan;
        r.command_num = cmd;
        r.ctrl_rule   = cr;
        r.shift_rule  = sr;
        r.alt_rule    = ar;
        enqueue(r);
        if (gen_count < TABLE_N) begin
            gen_count++;
            bound_scans = {bound_scans, scan};
        end
    endtask

    task automatic push_noise(input logic [2:0] code);
        hotkey_req_t r;
        r = random_req();
        r.req_type = code;
        enqueue(r);
    endtask

    // Driver
    hotkey_req_t in_flight;
    int          req_total = 0;
    int          per_type [8];
    logic        gap_free;

    assign gap_free = (req_total >= 600 && req_total < 900);

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                outcome_q = {outcome_q, translate_request(in_flight)};
                per_type[in_flight.req_type]++;
                req_total++;
            end
            if (!s_valid || s_ready) begin
                // hold a drain-marked request until every result is back
                if (request_q.size() != 0 && (gap_free || $urandom_range(99) >= 35)
                        && !(request_q[0].drain_first && outcome_q.size() != 0)) begin
                    in_flight = request_q.pop_front();
                    s_req_type    <= in_flight.req_type;
                    s_scan_code   <= in_flight.scan_code;
                    s_key_pressed <= in_flight.key_pressed;
                    s_ctrl_down   <= in_flight.ctrl_down;
                    s_shift_down  <= in_flight.shift_down;
                    s_alt_down    <= in_flight.alt_down;
                    s_force_clear <= in_flight.force_clear;
                    s_command_num <= in_flight.command_num;
                    s_ctrl_rule   <= in_flight.ctrl_rule;
                    s_shift_rule  <= in_flight.shift_rule;
                    s_alt_rule    <= in_flight.alt_rule;
                    s_valid       <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and scoreboard
    outcome_t want;
    int       mismatch_cnt    = 0;
    int       results_checked = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_checked++;
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected result found=%0b cmd=%0d acc=%0b on=%h",
                             $time, m_found, m_matched_command, m_accepted, m_on_mask);
                    mismatch_cnt++;
                end else begin
                    want = outcome_q.pop_front();
                    if (m_found !== want.found) begin
                        $display("%0t: found expected %0b actual %0b",
                                 $time, want.found, m_found);
                        mismatch_cnt++;
                    end
                    if (m_matched_command !== want.matched_command) begin
                        $display("%0t: matched_command expected %0d actual %0d",
                                 $time, want.matched_command, m_matched_command);
                        mismatch_cnt++;
                    end
                    if (m_accepted !== want.accepted) begin
                        $display("%0t: accepted expected %0b actual %0b",
                                 $time, want.accepted, m_accepted);
                        mismatch_cnt++;
                    end
                    if (m_on_mask !== want.on_mask) begin
                        $display("%0t: on_mask expected %h actual %h",
                                 $time, want.on_mask, m_on_mask);
                        mismatch_cnt++;
                    end
                end
            end
            m_ready <= gap_free || ($urandom_range(99) >= 35);
        end
    end

    // Watchdog: its limit lies far beyond any legal stall, such as a full-table walk
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG) begin
                $display("%0t: watchdog: no handshake for %0d cycles", $time, WATCHDOG);
                $display("Simulation FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int n;
        int pick;

        // Directed: empty table, extremes, shared scan codes, never rule, flag paths
        push_lookup(8'h3C, 1'b1, 1'b1, 1'b1);
        push_key(8'h3C, 1'b1, 1'b0, 1'b0, 1'b0);
        push_add(8'h00, 6'd0, RULE_EITHER, RULE_EITHER, RULE_EITHER);
        push_add(8'hFF, 6'd63, RULE_DOWN, RULE_UP, RULE_EITHER);
        push_add(8'hA5, 6'd21, RULE_EITHER, RULE_EITHER, RULE_NEVER);
        push_add(8'h5A, 6'd42, RULE_DOWN, RULE_DOWN, RULE_DOWN);
        push_add(8'hFF, 6'd5, RULE_UP, RULE_EITHER, RULE_UP);
        push_key(8'hFF, 1'b1, 1'b1, 1'b0, 1'b0);
        push_lookup(8'hFF, 1'b1, 1'b0, 1'b0);
        push_lookup(8'hFF, 1'b0, 1'b1, 1'b0);
        push_lookup(8'hA5, 1'b1, 1'b1, 1'b1);
        push_key(8'hA5, 1'b1, 1'b0, 1'b0, 1'b1);
        push_key(8'hFF, 1'b0, 1'b1, 1'b0, 1'b0);
        push_frame(1'b0);
        push_force(6'd10);
        push_force(6'd63);
        push_force(6'd10);
        push_frame(1'b1);
        push_key(8'h5A, 1'b1, 1'b1, 1'b1, 1'b1);
        push_key(8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
        push_noise(3'd5);
        push_noise(3'd6);
        push_noise(3'd7);
        push_key(8'h5A, 1'b0, 1'b0, 1'b0, 1'b0);
        push_frame(1'b0);

        // Random: mostly key traffic on bound scan codes, table kept small
        hold_for_drain = 1'b1;
        for (n = 0; n < RAND_N; n++) begin
            if (n == 500 || n == 1100) hold_for_drain = 1'b1;
            pick = $urandom_range(99);
            if (pick >= 82 && pick < 94 && gen_count < BUSY_CAP) begin
                push_add(($urandom_range(3) == 0 && bound_scans.size() != 0)
                             ? bound_scans[$urandom_range(bound_scans.size() - 1)]
                             : 8'($urandom_range(255)),
                         pick_command(), 2'($urandom_range(3)), 2'($urandom_range(3)),
                         2'($urandom_range(3)));
            end else if (pick < 45 || (pick >= 82 && pick < 94)) begin
                push_key(pick_scan(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
            end else if (pick < 65) begin
                push_lookup(pick_scan(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                            1'($urandom_range(1)));
            end else if (pick < 75) begin
                push_frame($urandom_range(3) == 0);
            end else if (pick < 82) begin
                push_force(pick_command());
            end else begin
                push_noise(3'($urandom_range(7, 5)));
            end
        end

        // Fill the table, try a few adds past capacity, then walk the full table
        hold_for_drain = 1'b1;
        while (gen_count < TABLE_N) begin
            push_add(8'($urandom_range(255)), pick_command(), 2'($urandom_range(3)),
                     2'($urandom_range(3)), 2'($urandom_range(3)));
        end
        for (n = 0; n < 4; n++) begin
            push_add(8'($urandom_range(255)), 6'($urandom_range(63)), 2'($urandom_range(3)),
                     2'($urandom_range(3)), 2'($urandom_range(3)));
        end
        for (n = 0; n < 12; n++) begin
            if (n % 3 == 0)
                push_lookup(bound_scans[TABLE_N - 1], 1'($urandom_range(1)),
                            1'($urandom_range(1)), 1'($urandom_range(1)));
            else if (n % 3 == 1)
                push_key(pick_scan(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                push_lookup(pick_scan(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                            1'($urandom_range(1)));
        end
        push_frame(1'b0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (request_q.size() != 0 || s_valid || outcome_q.size() != 0) @(posedge aclk);
        repeat (TAIL) @(posedge aclk);

        $display("Checked %0d results, %0d requests: %0d key, %0d lookup, %0d frame, %0d force,",
                 results_checked, req_total, per_type[0], per_type[1], per_type[2],
                 per_type[3]);
        $display("%0d adds, %0d unused; table %0d entries, %0d adds refused, %0d mismatches",
                 per_type[4], per_type[5] + per_type[6] + per_type[7], pred_count,
                 adds_refused, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/hkct_pkg.sv
rtl/core/hkct_front.sv
rtl/core/hkct_queue.sv
rtl/core/hkct_back.sv
rtl/core/hotkey_command_translator.sv
sim/hotkey_command_translator_tb.sv
